FILE: hw/rtl/fsd_pkg.sv
package fsd_pkg;

    // default sizing handed to the top level
    localparam int DEFAULT_MAX_WIDTH = 2048;
    localparam int DEFAULT_FRAC_BITS = 8;

    // configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

    // configuration reset values
    localparam logic [11:0] IMAGE_WIDTH_RESET  = 12'd640;
    localparam logic [15:0] IMAGE_HEIGHT_RESET = 16'd480;

    // output levels
    localparam logic [7:0] LEVEL_HIGH = 8'd255;
    localparam logic [7:0] LEVEL_LOW  = 8'd0;

    // reciprocal of 3 in 11 fraction bits, exact floor for sums up to 765
    localparam logic [19:0] GREY_RECIP = 20'd683;

    // position of a pixel within its row and frame
    typedef struct packed {
        logic row_zero;
        logic first_col;
        logic last_col;
    } fsd_pos_t;

    // floor((r + g + b) / 3)
    function automatic logic [7:0] grey_of(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        logic [9:0]  s;
        logic [19:0] p;
        s = 10'(r) + 10'(g) + 10'(b);
        p = 20'(s) * GREY_RECIP;
        return p[18:11];
    endfunction

endpackage

FILE: hw/rtl/fsd_err_mem.sv
module fsd_err_mem #(
    parameter int DEPTH = fsd_pkg::DEFAULT_MAX_WIDTH,
    parameter int DW    = fsd_pkg::DEFAULT_FRAC_BITS + 10
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic signed [DW-1:0]     rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic signed [DW-1:0]     wr_data
);

    logic signed [DW-1:0] mem [DEPTH];
    logic signed [DW-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds its word until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/fsd_diffuse.sv
module fsd_diffuse #(
    parameter int FRAC_BITS = fsd_pkg::DEFAULT_FRAC_BITS
) (
    input  logic [7:0]                 grey,
    input  fsd_pkg::fsd_pos_t          pos,
    input  logic signed [FRAC_BITS+9:0] carry,
    input  logic signed [FRAC_BITS+9:0] err_in,
    input  logic signed [FRAC_BITS+9:0] np0,
    input  logic signed [FRAC_BITS+9:0] np1,
    output logic [7:0]                 level,
    output logic signed [FRAC_BITS+9:0] carry_upd,
    output logic signed [FRAC_BITS+9:0] np0_upd,
    output logic signed [FRAC_BITS+9:0] np1_upd,
    output logic signed [FRAC_BITS+9:0] left_data,
    output logic signed [FRAC_BITS+9:0] last_data
);

    localparam int EW = FRAC_BITS + 10;
    localparam int SW = FRAC_BITS + 16;
    localparam logic signed [SW-1:0] ERR_LIMIT = SW'((64'sd1 <<< (FRAC_BITS + 9)) - 64'sd1);
    localparam logic signed [SW-1:0] THRESH    = SW'(255) <<< (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] FULL      = SW'(255) <<< FRAC_BITS;

    function automatic logic signed [EW-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        if (v > ERR_LIMIT) begin
            r = ERR_LIMIT;
        end else if (v < -ERR_LIMIT) begin
            r = -ERR_LIMIT;
        end else begin
            r = v;
        end
        return EW'(r);
    endfunction

    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] e;
    logic signed [SW-1:0] sh7, sh5, sh3, sh1;
    logic                 high;
    logic signed [EW-1:0] below;

    // grey plus diffused error, then quantize
    always_comb begin
        sum  = signed'(SW'(grey) <<< FRAC_BITS) + SW'(carry);
        if (!pos.row_zero) begin
            sum = sum + SW'(err_in);
        end
        high = sum > THRESH;
        e    = high ? (sum - FULL) : sum;
    end

    // shares of the error, floor of e*w/16
    always_comb begin
        sh7 = ((e <<< 3) - e) >>> 4;
        sh5 = ((e <<< 2) + e) >>> 4;
        sh3 = ((e <<< 1) + e) >>> 4;
        sh1 = e >>> 4;
    end

    // next-row sums and carry
    always_comb begin
        below     = sat(SW'(np1) + sh5);
        left_data = sat(SW'(np0) + sh3);
        last_data = below;
        carry_upd = pos.last_col ? '0 : sat(sh7);
        np0_upd   = pos.last_col ? '0 : below;
        np1_upd   = pos.last_col ? '0 : sat(sh1);
        level     = high ? fsd_pkg::LEVEL_HIGH : fsd_pkg::LEVEL_LOW;
    end

endmodule

FILE: hw/rtl/floyd_steinberg_binary_dither.sv
// Floyd-Steinberg binary dither, one RGBA pixel in and one result out per word.
// Path: a word passes the read stage, then the diffuse stage, then the output register.
// Throughput: 1 pixel per cycle unless the output stalls, set by the right-error loop
// in the diffuse stage and the one read port plus one write port of the error line memory.
// Reset: synchronous active-low aresetn clears counters, carries and valids;
// the error line memory is not cleared, row zero of every frame ignores its read data.
module floyd_steinberg_binary_dither #(
    parameter int MAX_WIDTH = fsd_pkg::DEFAULT_MAX_WIDTH,
    parameter int FRAC_BITS = fsd_pkg::DEFAULT_FRAC_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // pixel input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_red,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_blue,
    input  logic [7:0]  s_alpha,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_level,
    output logic [7:0]  m_alpha_out
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int EW = FRAC_BITS + 10;

    // configuration and position
    logic [11:0]          width_reg;
    logic [15:0]          height_reg;
    logic [AW-1:0]        col_reg, col_next;
    logic [15:0]          row_reg, row_next;
    logic                 restart;

    // diffuse stage
    logic                 p1_valid_reg;
    logic [7:0]           p1_grey_reg;
    logic [7:0]           p1_alpha_reg;
    logic [AW-1:0]        p1_col_reg;
    fsd_pkg::fsd_pos_t    p1_pos_reg;

    // error state
    logic signed [EW-1:0] carry_reg, carry_next;
    logic signed [EW-1:0] np0_reg, np0_next;
    logic signed [EW-1:0] np1_reg, np1_next;

    // forwarding and deferred write
    logic                 fwd_valid_reg;
    logic signed [EW-1:0] fwd_data_reg;
    logic                 pend_valid_reg, pend_valid_next;
    logic [AW-1:0]        pend_addr_reg;
    logic signed [EW-1:0] pend_data_reg;

    // output register
    logic                 m_valid_reg;
    logic [7:0]           m_level_reg;
    logic [7:0]           m_alpha_reg;

    logic                 out_free, p1_adv, s_acc;
    logic [AW:0]          w_eff;
    logic [15:0]          h_eff;
    logic                 acc_last;
    logic [16:0]          row_inc;
    logic                 left_we;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic signed [EW-1:0] mem_wdata;
    logic signed [EW-1:0] mem_rdata;
    logic signed [EW-1:0] err_eff;
    logic [AW-1:0]        cur_addr;
    fsd_pkg::fsd_pos_t    acc_pos;

    logic [7:0]           d_level;
    logic signed [EW-1:0] d_carry, d_np0, d_np1, d_left, d_last;

    // handshake
    assign out_free = !m_valid_reg || m_ready;
    assign p1_adv   = p1_valid_reg && out_free;
    assign s_ready  = !p1_valid_reg || out_free;
    assign s_acc    = s_valid && s_ready;

    // configuration decode
    always_comb begin
        restart = 1'b0;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                fsd_pkg::REG_IMAGE_WIDTH:  restart = 1'b1;
                fsd_pkg::REG_IMAGE_HEIGHT: restart = 1'b1;
                default:                   restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= fsd_pkg::IMAGE_WIDTH_RESET;
            height_reg <= fsd_pkg::IMAGE_HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                fsd_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[11:0];
                fsd_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamped frame size
    always_comb begin
        if (width_reg == '0) begin
            w_eff = (AW+1)'(1);
        end else if (int'(width_reg) > MAX_WIDTH) begin
            w_eff = (AW+1)'(MAX_WIDTH);
        end else begin
            w_eff = (AW+1)'(width_reg);
        end
        h_eff = (height_reg == '0) ? 16'd1 : height_reg;
    end

    // raster position of the word being accepted
    always_comb begin
        acc_last = ({1'b0, col_reg} + (AW+1)'(1)) >= w_eff;
        row_inc  = 17'(row_reg) + 17'd1;
        col_next = col_reg;
        row_next = row_reg;
        if (s_acc) begin
            if (acc_last) begin
                col_next = '0;
                row_next = (row_inc >= {1'b0, h_eff}) ? 16'd0 : row_inc[15:0];
            end else begin
                col_next = col_reg + AW'(1);
            end
        end
        acc_pos.row_zero  = (row_reg == '0);
        acc_pos.first_col = (col_reg == '0);
        acc_pos.last_col  = acc_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // read stage into diffuse stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_acc) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_adv) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            p1_grey_reg  <= fsd_pkg::grey_of(s_red, s_green, s_blue);
            p1_alpha_reg <= s_alpha;
            p1_col_reg   <= col_reg;
            p1_pos_reg   <= acc_pos;
        end
    end

    // error line memory
    assign left_we   = p1_adv && !p1_pos_reg.first_col;
    assign mem_we    = left_we || pend_valid_reg;
    assign mem_waddr = left_we ? (p1_col_reg - AW'(1)) : pend_addr_reg;
    assign mem_wdata = left_we ? d_left : pend_data_reg;

    fsd_err_mem #(
        .DEPTH (MAX_WIDTH),
        .DW    (EW)
    ) u_err_mem (
        .aclk    (aclk),
        .rd_en   (s_acc),
        .rd_addr (col_reg),
        .rd_data (mem_rdata),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata)
    );

    // last column entry is held in the pending register and written once the write port is free
    always_comb begin
        pend_valid_next = pend_valid_reg && left_we;
        if (p1_adv && p1_pos_reg.last_col) begin
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv && p1_pos_reg.last_col) begin
            pend_addr_reg <= p1_col_reg;
            pend_data_reg <= d_last;
        end
    end

    // catch writes that land on the entry held in the read register
    assign cur_addr = s_acc ? col_reg : p1_col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (mem_we && (mem_waddr == cur_addr)) begin
            fwd_valid_reg <= 1'b1;
        end else if (s_acc) begin
            fwd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we && (mem_waddr == cur_addr)) begin
            fwd_data_reg <= mem_wdata;
        end
    end

    // newest value of the entry for the diffuse stage
    always_comb begin
        if (pend_valid_reg && (pend_addr_reg == p1_col_reg)) begin
            err_eff = pend_data_reg;
        end else if (fwd_valid_reg) begin
            err_eff = fwd_data_reg;
        end else begin
            err_eff = mem_rdata;
        end
    end

    fsd_diffuse #(
        .FRAC_BITS (FRAC_BITS)
    ) u_diffuse (
        .grey      (p1_grey_reg),
        .pos       (p1_pos_reg),
        .carry     (carry_reg),
        .err_in    (err_eff),
        .np0       (np0_reg),
        .np1       (np1_reg),
        .level     (d_level),
        .carry_upd (d_carry),
        .np0_upd   (d_np0),
        .np1_upd   (d_np1),
        .left_data (d_left),
        .last_data (d_last)
    );

    // right carry and next-row partial sums
    always_comb begin
        carry_next = carry_reg;
        np0_next   = np0_reg;
        np1_next   = np1_reg;
        if (p1_adv) begin
            carry_next = d_carry;
            np0_next   = d_np0;
            np1_next   = d_np1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            carry_reg <= '0;
            np0_reg   <= '0;
            np1_reg   <= '0;
        end else begin
            carry_reg <= carry_next;
            np0_reg   <= np0_next;
            np1_reg   <= np1_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_adv) begin
            m_level_reg <= d_level;
            m_alpha_reg <= p1_alpha_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_level     = m_level_reg;
    assign m_alpha_out = m_alpha_reg;

endmodule

FILE: hw/rtl/fsd_checker.sv
module fsd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_level,
    input logic [7:0] m_alpha_out
);

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_level) && $stable(m_alpha_out))
        else $error("result word changed while stalled");

    // levels are binary
    a_level_binary: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_level == 8'd0 || m_level == 8'd255))
        else $error("level is neither 0 nor 255");

    // input only backs up behind a full, stalled output
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

    // a word taken while the output register is empty shows up behind the diffuse stage if m_ready is high
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid ##1 m_ready |=> m_valid)
        else $error("result missing after two cycles");

endmodule

bind floyd_steinberg_binary_dither fsd_checker u_fsd_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_level     (m_level),
    .m_alpha_out (m_alpha_out)
);
